/* rtl/rtc_pkg.sv */
// Shared constants, types and codes for the route transposition cipher.
package rtc_pkg;

  // Message store geometry.
  localparam int MAX_LEN  = 64;
  localparam int ADDR_W   = $clog2(MAX_LEN);
  localparam int CNT_W    = $clog2(MAX_LEN + 1);
  localparam int CELL_W   = CNT_W + 1;
  localparam int DIV_CNT_W = $clog2(ADDR_W + 1);

  // Field widths.
  localparam int CHAR_W   = 8;
  localparam int KEY_W    = 8;
  localparam int STATUS_W = 2;
  localparam int CLAMP_W  = ((KEY_W > CNT_W) ? KEY_W : CNT_W) + 1;

  // Configuration port.
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam logic REG_KEY = 1'b0;
  localparam logic REG_DIR = 1'b1;

  // Direction codes.
  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  // Character constants.
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

  // Extra columns allowed above half the message length.
  localparam int KEY_LIM_ADD = 3;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_BURST
  } state_t;

  // Table shape produced by the divider.
  typedef struct packed {
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] full;
  } div_res_t;

endpackage

/* rtl/rtc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module rtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/rtc_div.sv */
// Restoring divider that derives the row count and last-row fill of the table.
module rtc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rtc_pkg::ADDR_W-1:0] dividend,
  input  logic [rtc_pkg::CNT_W-1:0]  divisor,
  output logic                      done,
  output rtc_pkg::div_res_t         res
);

  import rtc_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] step_r;
  logic [CNT_W-1:0]     rem_r;
  logic [ADDR_W-1:0]    dvd_r;
  logic [ADDR_W-1:0]    quo_r;
  logic [CNT_W-1:0]     dsr_r;

  logic [CELL_W-1:0]    trial;
  logic                 fits;
  logic [CNT_W-1:0]     rem_nxt;
  logic [ADDR_W-1:0]    quo_nxt;

  // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial   = {rem_r, dvd_r[ADDR_W-1]};
    fits    = (trial >= {1'b0, dsr_r});
    rem_nxt = fits ? CNT_W'(trial - {1'b0, dsr_r}) : CNT_W'(trial);
    quo_nxt = (quo_r << 1) | ADDR_W'(fits);
  end

  // Control: step counter and done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && !start && (step_r == DIV_CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        step_r <= DIV_CNT_W'(ADDR_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath: partial remainder, shifting dividend and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      quo_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_r << 1;
      quo_r <= quo_nxt;
    end
  end

  // Rows is quotient plus one and the last row holds remainder plus one cells.
  assign done     = done_r;
  assign res.rows = CNT_W'(quo_r) + 1'b1;
  assign res.full = rem_r + 1'b1;

endmodule

/* rtl/route_transposition_cipher.sv */
// Columnar transposition cipher read from the rightmost column, top level.
// Bytes are accepted while busy is low; each accepted letter is stored until the store is full.
// After the last byte the divider works out six quotient bits and raises done, then a setup
// state prepares the walk and the burst reads the store; results follow one letter per cycle.
// An empty message answers in the next cycle.
// Synchronous reset clears counters and sequencer, key to 1, encrypt; results never stall.
module route_transposition_cipher (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input request channel.
  input  logic                          start,
  output logic                          busy,
  input  logic [rtc_pkg::CHAR_W-1:0]    in_char,
  input  logic                          in_last,
  // Result channel.
  output logic                          out_valid,
  output logic [rtc_pkg::CHAR_W-1:0]    out_char,
  output logic                          out_last,
  output logic [rtc_pkg::STATUS_W-1:0]  out_status,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rtc_pkg::PADDR_W-1:0]   paddr,
  input  logic [rtc_pkg::PDATA_W-1:0]   pwdata,
  output logic [rtc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  import rtc_pkg::*;

  // Configuration registers.
  logic [KEY_W-1:0] key_r;
  logic             direction_r;
  logic             cfg_write;

  // Sequencer and message state.
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  letter_count_r, letter_count_nxt;
  logic              overflow_r, overflow_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  kk_r, kk_nxt;
  logic              dir_r, dir_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic [CNT_W-1:0]  rows_r, rows_nxt;
  logic [CNT_W-1:0]  full_r, full_nxt;
  logic [CELL_W-1:0] cell_r, cell_nxt;
  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;
  logic [CNT_W-1:0]  base_r, base_nxt;
  logic [CNT_W-1:0]  issued_r, issued_nxt;

  // Read pipeline flags aligned with the RAM output.
  logic pend_valid_r, pend_valid_nxt;
  logic pend_last_r, pend_last_nxt;
  logic pend_err_r, pend_err_nxt;

  // Store ports.
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CHAR_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CHAR_W-1:0] rd_data;

  // Divider ports.
  logic              div_start;
  logic [ADDR_W-1:0] div_dividend;
  logic              div_done;
  div_res_t          div_res;

  // Load-time helpers.
  logic              accept;
  logic [CHAR_W-1:0] up_char;
  logic              is_letter;
  logic              keep;
  logic [CNT_W-1:0]  count_inc;
  logic [CLAMP_W-1:0] key_ext;
  logic [CLAMP_W-1:0] key_lim;
  logic [CLAMP_W-1:0] len_ext;
  logic [CLAMP_W-1:0] kk_clamped;
  logic              is_final;

  // Configuration writes and reads; the low address bits are the byte offset.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= KEY_W'(1);
      direction_r <= DIR_ENCRYPT;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_KEY: key_r       <= pwdata[KEY_W-1:0];
        REG_DIR: direction_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_KEY: prdata = PDATA_W'(key_r);
      REG_DIR: prdata = PDATA_W'(direction_r);
      default: prdata = '0;
    endcase
  end

  // Letter filter and case folding.
  assign accept    = start && !busy;
  assign up_char   = ((in_char >= CHAR_LOWER_A) && (in_char <= CHAR_LOWER_Z)) ?
                     (in_char - CASE_OFFSET) : in_char;
  assign is_letter = (up_char >= CHAR_UPPER_A) && (up_char <= CHAR_UPPER_Z);
  assign keep      = is_letter && (letter_count_r < CNT_W'(MAX_LEN));
  assign count_inc = letter_count_r + CNT_W'(keep);

  // Column count clamp: at least one, at most len/2+3, and never above the length.
  always_comb begin
    len_ext    = CLAMP_W'(count_inc);
    key_ext    = (key_r == '0) ? CLAMP_W'(1) : CLAMP_W'(key_r);
    key_lim    = CLAMP_W'(count_inc >> 1) + CLAMP_W'(KEY_LIM_ADD);
    kk_clamped = key_ext;
    if (kk_clamped > key_lim) begin
      kk_clamped = key_lim;
    end
    if (kk_clamped > len_ext) begin
      kk_clamped = len_ext;
    end
  end

  assign is_final = (issued_r == (len_r - 1'b1));

  // Sequencer: load, divide, set up the walk, then stream the burst.
  always_comb begin
    state_nxt        = state_r;
    letter_count_nxt = letter_count_r;
    overflow_nxt     = overflow_r;
    len_nxt          = len_r;
    kk_nxt           = kk_r;
    dir_nxt          = dir_r;
    st_nxt           = st_r;
    rows_nxt         = rows_r;
    full_nxt         = full_r;
    cell_nxt         = cell_r;
    col_nxt          = col_r;
    row_nxt          = row_r;
    base_nxt         = base_r;
    issued_nxt       = issued_r;
    pend_valid_nxt   = 1'b0;
    pend_last_nxt    = 1'b0;
    pend_err_nxt     = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = letter_count_r[ADDR_W-1:0];
    wr_data          = up_char;
    rd_en            = 1'b0;
    rd_addr          = cell_r[ADDR_W-1:0];
    div_start        = 1'b0;
    div_dividend     = ADDR_W'(count_inc - 1'b1);

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          wr_en            = keep;
          letter_count_nxt = count_inc;
          overflow_nxt     = overflow_r || (is_letter && !keep);
          if (in_last) begin
            letter_count_nxt = '0;
            overflow_nxt     = 1'b0;
            st_nxt = (overflow_r || (is_letter && !keep)) ? STATUS_OVERFLOW : STATUS_OK;
            if (count_inc == '0) begin
              // Empty message: one error result next cycle.
              st_nxt         = STATUS_EMPTY;
              pend_valid_nxt = 1'b1;
              pend_last_nxt  = 1'b1;
              pend_err_nxt   = 1'b1;
            end else begin
              len_nxt   = count_inc;
              kk_nxt    = CNT_W'(kk_clamped);
              dir_nxt   = direction_r;
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
          end
        end
      end

      ST_DIV: begin
        if (div_done) begin
          rows_nxt  = div_res.rows;
          full_nxt  = div_res.full;
          state_nxt = ST_SETUP;
        end
      end

      ST_SETUP: begin
        issued_nxt = '0;
        cell_nxt   = CELL_W'(kk_r - 1'b1);
        col_nxt    = (dir_r == DIR_ENCRYPT) ? (kk_r - 1'b1) : '0;
        row_nxt    = '0;
        base_nxt   = len_r - rows_r;
        state_nxt  = ST_BURST;
      end

      ST_BURST: begin
        rd_en          = 1'b1;
        rd_addr        = (dir_r == DIR_ENCRYPT) ? cell_r[ADDR_W-1:0] :
                         ADDR_W'(base_r + row_r);
        pend_valid_nxt = 1'b1;
        pend_last_nxt  = is_final;
        issued_nxt     = issued_r + 1'b1;
        if (is_final) begin
          state_nxt = ST_IDLE;
        end
        if (dir_r == DIR_ENCRYPT) begin
          // Walk down the column, then move one column left.
          if ((cell_r + CELL_W'(kk_r)) < CELL_W'(len_r)) begin
            cell_nxt = cell_r + CELL_W'(kk_r);
          end else begin
            col_nxt  = col_r - 1'b1;
            cell_nxt = CELL_W'(col_r - 1'b1);
          end
        end else begin
          // Walk the table in row order; base counts cells in columns to the right.
          if ((col_r + 1'b1) == kk_r) begin
            col_nxt  = '0;
            row_nxt  = row_r + 1'b1;
            base_nxt = len_r - rows_r;
          end else begin
            col_nxt  = col_r + 1'b1;
            base_nxt = ((col_r + 1'b1) < full_r) ? (base_r - rows_r) :
                       (base_r - rows_r + 1'b1);
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      letter_count_r <= '0;
      overflow_r     <= 1'b0;
      pend_valid_r   <= 1'b0;
      pend_last_r    <= 1'b0;
      pend_err_r     <= 1'b0;
      issued_r       <= '0;
    end else begin
      state_r        <= state_nxt;
      letter_count_r <= letter_count_nxt;
      overflow_r     <= overflow_nxt;
      pend_valid_r   <= pend_valid_nxt;
      pend_last_r    <= pend_last_nxt;
      pend_err_r     <= pend_err_nxt;
      issued_r       <= issued_nxt;
    end
  end

  // Per-message payload registers.
  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    kk_r   <= kk_nxt;
    dir_r  <= dir_nxt;
    st_r   <= st_nxt;
    rows_r <= rows_nxt;
    full_r <= full_nxt;
    cell_r <= cell_nxt;
    col_r  <= col_nxt;
    row_r  <= row_nxt;
    base_r <= base_nxt;
  end

  // Letter store.
  rtc_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Table shape divider.
  rtc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (CNT_W'(kk_clamped)),
    .done     (div_done),
    .res      (div_res)
  );

  // Outputs.
  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = pend_valid_r;
  assign out_char   = pend_err_r ? '0 : rd_data;
  assign out_last   = pend_last_r;
  assign out_status = st_r;

  // A burst never has gaps: every result that is not last is followed by another.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("burst gap before the last result");

  // The last byte of a message always leaves the load counters cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |=> (letter_count_r == '0) && !overflow_r)
    else $error("load counters not cleared after the last byte");

  // An empty-message result is a single last result with a zero character.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_EMPTY) |-> out_last && (out_char == '0))
    else $error("malformed empty-message result");

  // The burst never reads more letters than the message holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BURST) |-> (issued_r < len_r))
    else $error("burst read past the message length");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the route transposition cipher block.
`timescale 1ns / 1ps

module tb_top;
  import rtc_pkg::*;

  // Result count per message is bounded by the store depth.
  localparam int BURST_SETTLE = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TOTAL_ITEMS  = 125;

  localparam logic [PADDR_W-1:0] KEY_ADDR = {REG_KEY, 2'b00};
  localparam logic [PADDR_W-1:0] DIR_ADDR = {REG_DIR, 2'b00};

  // One expected cipher letter as it should appear on the result ports.
  typedef struct {
    logic [CHAR_W-1:0]   ch;
    logic                last;
    logic [STATUS_W-1:0] st;
  } cipher_letter_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [CHAR_W-1:0]   in_char;
  logic                in_last;
  logic                out_valid;
  logic [CHAR_W-1:0]   out_char;
  logic                out_last;
  logic [STATUS_W-1:0] out_status;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // Predictor state: letters loaded so far and the register copies.
  logic [CHAR_W-1:0]   msg_letters [MAX_LEN];
  int unsigned         msg_len;
  logic                msg_dropped;
  logic [KEY_W-1:0]    key_reg;
  logic                dir_reg;

  cipher_letter_t      expected_cipher_q[$];
  int                  err_count;
  int                  letters_checked;
  int                  messages_sent;
  int                  counted_items;
  int                  cfg_writes;
  longint              cycle_count;

  route_transposition_cipher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_char   (in_char),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_char  (out_char),
    .out_last  (out_last),
    .out_status(out_status),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Free-running 2 ns clock.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Build the permuted message from the letters loaded and queue its results.
  task automatic permute_message();
    int unsigned k, rows, col, r, slot, seq, lim;
    logic [CHAR_W-1:0] perm [MAX_LEN];
    logic [STATUS_W-1:0] st;
    cipher_letter_t item;
    begin
      st = msg_dropped ? STATUS_OVERFLOW : STATUS_OK;
      if (msg_len == 0) begin
        item.ch = '0;
        item.last = 1'b1;
        item.st = STATUS_EMPTY;
        expected_cipher_q.insert(expected_cipher_q.size(), item);
      end else begin
        // Clamp the column count to half the length plus the margin.
        lim = msg_len / 2 + KEY_LIM_ADD;
        k = (key_reg == 0) ? 1 : key_reg;
        if (k > lim) k = lim;
        rows = (msg_len + k - 1) / k;
        seq = 0;
        for (col = k; col > 0; col--) begin
          for (r = 0; r < rows; r++) begin
            slot = r * k + col - 1;
            if (slot < msg_len) begin
              if (dir_reg == DIR_ENCRYPT) perm[seq] = msg_letters[slot];
              else perm[slot] = msg_letters[seq];
              seq++;
            end
          end
        end
        for (int i = 0; i < msg_len; i++) begin
          item.ch = perm[i];
          item.last = (i + 1 == msg_len);
          item.st = st;
          expected_cipher_q.insert(expected_cipher_q.size(), item);
        end
      end
      msg_len = 0;
      msg_dropped = 1'b0;
    end
  endtask

  // Fold one accepted byte into the predictor.
  task automatic absorb_byte(input logic [CHAR_W-1:0] c, input logic last);
    logic [CHAR_W-1:0] u;
    begin
      u = c;
      if (u >= CHAR_LOWER_A && u <= CHAR_LOWER_Z) u = u - CASE_OFFSET;
      if (u >= CHAR_UPPER_A && u <= CHAR_UPPER_Z) begin
        if (msg_len < MAX_LEN) begin
          msg_letters[msg_len] = u;
          msg_len++;
        end else begin
          msg_dropped = 1'b1;
        end
      end
      if (last) begin
        permute_message();
        messages_sent++;
      end
    end
  endtask

  // Send one request after a random gap; start stays high on return.
  // Entered and left just after a falling edge.
  task automatic send_byte(input logic [CHAR_W-1:0] c, input logic last);
    int gap;
    begin
      gap = $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk);
      end
      start = 1'b1;
      in_char = c;
      in_last = last;
      do @(posedge clk); while (busy);
      absorb_byte(c, last);
      counted_items++;
      @(negedge clk);
    end
  endtask

  // Send a whole message from a byte queue, the last byte marked.
  task automatic send_message(input logic [CHAR_W-1:0] bytes[$]);
    begin
      for (int i = 0; i < bytes.size(); i++) send_byte(bytes[i], i == bytes.size() - 1);
    end
  endtask

  // Let every queued result arrive, then let the block settle.
  task automatic drain();
    begin
      start = 1'b0;
      while (expected_cipher_q.size() != 0) @(negedge clk);
      repeat (BURST_SETTLE) @(negedge clk);
    end
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    begin
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = addr;
      pwdata = data;
      @(negedge clk);
      penable = 1'b1;
      do @(posedge clk); while (!pready);
      if (addr == KEY_ADDR) key_reg = data[KEY_W-1:0];
      else dir_reg = data[0];
      cfg_writes++;
      @(negedge clk);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
    end
  endtask

  // Register read, compared with the predictor's copy.
  task automatic cfg_check(input logic [PADDR_W-1:0] addr);
    logic [PDATA_W-1:0] want;
    begin
      want = (addr == KEY_ADDR) ? PDATA_W'(key_reg) : PDATA_W'(dir_reg);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = addr;
      @(negedge clk);
      penable = 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata !== want) begin
        $display("%0t: register %0d read expected %h actual %h", $time, addr, want, prdata);
        err_count++;
      end
      @(negedge clk);
      psel = 1'b0;
      penable = 1'b0;
    end
  endtask

  // Idle point: drain, then set both registers.
  task automatic reconfigure(input logic [KEY_W-1:0] key, input logic dir);
    begin
      drain();
      cfg_write(KEY_ADDR, PDATA_W'(key));
      cfg_write(DIR_ADDR, PDATA_W'(dir));
    end
  endtask

  // Compare each strobed result with the oldest expectation.
  always @(posedge clk) begin : result_check
    cipher_letter_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_cipher_q.size() == 0) begin
        $display("%0t: unexpected result char %h last %b status %0d", $time, out_char,
                 out_last, out_status);
        err_count++;
      end else begin
        want = expected_cipher_q.pop_front();
        letters_checked++;
        if (out_char !== want.ch) begin
          $display("%0t: char expected %h actual %h", $time, want.ch, out_char);
          err_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, out_last);
          err_count++;
        end
        if (out_status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, out_status);
          err_count++;
        end
      end
    end
  end

  // Reset values, then every register at its extremes with readback.
  task automatic test_registers();
    begin
      cfg_check(KEY_ADDR);
      cfg_check(DIR_ADDR);
      cfg_write(KEY_ADDR, PDATA_W'(8'd255));
      cfg_check(KEY_ADDR);
      cfg_write(KEY_ADDR, '0);
      cfg_check(KEY_ADDR);
      cfg_write(DIR_ADDR, PDATA_W'(DIR_DECRYPT));
      cfg_check(DIR_ADDR);
      cfg_write(DIR_ADDR, PDATA_W'(DIR_ENCRYPT));
      cfg_check(DIR_ADDR);
    end
  endtask

  // Short directed messages: byte extremes, case folding, empty message, key edges.
  task automatic test_directed();
    begin
      // Letter boundaries and non-letters next to them, key three, encrypt.
      reconfigure(8'd3, DIR_ENCRYPT);
      send_message('{8'h61, 8'h5A, 8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h6D});
      // A message with no letters at all.
      send_message('{8'h00});
      // Key zero acts as one column.
      reconfigure(8'd0, DIR_ENCRYPT);
      send_message('{8'h41, 8'h7A});
      // Key far above the length: one row read right to left.
      reconfigure(8'd255, DIR_ENCRYPT);
      send_message('{8'h41, 8'h7A});
      send_message('{"h", "e", "l", "l", "o"});
      // Decrypt with two columns, then a single letter.
      reconfigure(8'd2, DIR_DECRYPT);
      send_message('{"c", "i", "p", "h", "e", "r"});
      send_message('{"q"});
    end
  endtask

  // Full store, then letters past it and a non-letter, then a clean decrypt message.
  task automatic test_overflow();
    logic [CHAR_W-1:0] bytes[$];
    begin
      reconfigure(8'd7, DIR_ENCRYPT);
      bytes = {};
      for (int i = 0; i < MAX_LEN + 2; i++) begin
        bytes.insert(bytes.size(), CHAR_W'(8'h41 + (i % 26)));
      end
      bytes.insert(bytes.size(), 8'h2E);
      send_message(bytes);
      reconfigure(8'd5, DIR_DECRYPT);
      send_message('{"o", "k"});
    end
  endtask

  // Random messages under random settings until the item budget is used.
  task automatic test_random();
    logic [CHAR_W-1:0] bytes[$];
    logic [KEY_W-1:0] key;
    int n, choice;
    begin
      while (counted_items < TOTAL_ITEMS) begin
        // Change settings now and then; key extremes come up often.
        if ($urandom_range(0, 3) == 0) begin
          choice = $urandom_range(0, 5);
          case (choice)
            0: key = 8'd0;
            1: key = 8'd1;
            2: key = 8'd255;
            default: key = KEY_W'($urandom_range(2, 40));
          endcase
          reconfigure(key, 1'($urandom_range(0, 1)));
        end else if ($urandom_range(0, 7) == 0) begin
          drain();
        end
        // Mostly letters of random case, some arbitrary bytes; rarely long.
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 14);
        bytes = {};
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) == 0) begin
            bytes.insert(bytes.size(), CHAR_W'($urandom_range(0, 255)));
          end else if ($urandom_range(0, 1) == 0) begin
            bytes.insert(bytes.size(), CHAR_W'(8'h41 + $urandom_range(0, 25)));
          end else begin
            bytes.insert(bytes.size(), CHAR_W'(8'h61 + $urandom_range(0, 25)));
          end
        end
        send_message(bytes);
      end
    end
  endtask

  // Main sequence.
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_char = '0;
    in_last = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cycle_count = 0;
    err_count = 0;
    letters_checked = 0;
    messages_sent = 0;
    counted_items = 0;
    cfg_writes = 0;
    msg_len = 0;
    msg_dropped = 1'b0;
    key_reg = 8'd1;
    dir_reg = DIR_ENCRYPT;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_registers();
    test_directed();
    test_overflow();
    test_random();

    // Wait out the last burst, then report.
    drain();
    $display("Sent %0d bytes in %0d messages with %0d register writes; checked %0d results.",
             counted_items, messages_sent, cfg_writes, letters_checked);
    $display("Covered both directions, key extremes, empty and overflowing messages.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/rtc_pkg.sv
rtl/rtc_ram.sv
rtl/rtc_div.sv
rtl/route_transposition_cipher.sv
sim/tb_top.sv
